// ----- rtl/core/sorted_draw_queue_defines.svh -----
// ----------------------------------------------------------------------------
// sorted_draw_queue assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SORTED_DRAW_QUEUE_DEFINES_SVH
`define SORTED_DRAW_QUEUE_DEFINES_SVH

// condition holds at every edge out of reset
`define SDQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent holds in the cycle of the antecedent
`define SDQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdq_pkg
// shared types and constants of the sorted draw queue
// ----------------------------------------------------------------------------
package sdq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned KEY_BITS_DEF    = 16;
  localparam int unsigned TEX_W           = 10;
  localparam int unsigned HANDLE_W        = 12;
  localparam int unsigned STATUS_W        = 2;

  // command codes carried in the input tuser
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENTRY = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DROP  = 2'd2
  } sdq_status_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic ins;      // insert the broadcast entry this cycle
    logic shift;    // drain: every cell takes its right neighbor
  } sdq_cell_ctrl_t;

endpackage

// ----- rtl/core/sdq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdq_cell
// one slot of the insertion chain: holds an entry, compares against the
// broadcast key and shifts toward the tail on insert or toward the head on drain
// ----------------------------------------------------------------------------
module sdq_cell #(
  parameter int unsigned KEY_BITS = sdq_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdq_pkg::sdq_cell_ctrl_t       ctrl,
  input  logic [KEY_BITS-1:0]           new_key,
  input  logic [sdq_pkg::TEX_W-1:0]     new_tex,
  input  logic [sdq_pkg::HANDLE_W-1:0]  new_handle,
  input  logic                          left_gt,
  input  logic                          left_valid,
  input  logic [KEY_BITS-1:0]           left_key,
  input  logic [sdq_pkg::TEX_W-1:0]     left_tex,
  input  logic [sdq_pkg::HANDLE_W-1:0]  left_handle,
  input  logic                          right_valid,
  input  logic [KEY_BITS-1:0]           right_key,
  input  logic [sdq_pkg::TEX_W-1:0]     right_tex,
  input  logic [sdq_pkg::HANDLE_W-1:0]  right_handle,
  output logic                          gt,
  output logic                          valid,
  output logic [KEY_BITS-1:0]           key,
  output logic [sdq_pkg::TEX_W-1:0]     tex,
  output logic [sdq_pkg::HANDLE_W-1:0]  handle
);
  import sdq_pkg::*;

  logic                valid_r, valid_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [TEX_W-1:0]    tex_r, tex_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;

  // empty slots count as larger so the new entry lands in the first free one
  assign gt = !valid_r || ($signed(key_r) > $signed(new_key));

  always_comb begin
    valid_nxt  = valid_r;
    key_nxt    = key_r;
    tex_nxt    = tex_r;
    handle_nxt = handle_r;
    if (ctrl.ins && gt) begin
      if (left_gt) begin
        valid_nxt  = left_valid;
        key_nxt    = left_key;
        tex_nxt    = left_tex;
        handle_nxt = left_handle;
      end else begin
        valid_nxt  = 1'b1;
        key_nxt    = new_key;
        tex_nxt    = new_tex;
        handle_nxt = new_handle;
      end
    end else if (ctrl.shift) begin
      valid_nxt  = right_valid;
      key_nxt    = right_key;
      tex_nxt    = right_tex;
      handle_nxt = right_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    tex_r    <= tex_nxt;
    handle_r <= handle_nxt;
  end

  assign valid  = valid_r;
  assign key    = key_r;
  assign tex    = tex_r;
  assign handle = handle_r;

endmodule

// ----- rtl/core/sorted_draw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_draw_queue
// draw entry queue kept in ascending signed key order by a chain of cells
// ----------------------------------------------------------------------------
//  channel | ports       | tdata (low bit up)              | tuser    | tlast
//  --------+-------------+---------------------------------+----------+------
//  in      | in_t*       | sort_key, texture_id, item_hdl  | cmd      | -
//  out     | out_t*      | out_key, out_texture, out_hdl   | status   | last
//
//  insert: one beat per cycle, placed in the chain in the cycle it is taken;
//    every cell compares its key to the broadcast key in parallel
//  drain: one result beat per cycle per held entry, the chain shifting one
//    cell toward the head per beat; no input beat is taken until the run ends
//  a full-queue insert or an empty drain gives one result beat
//  output stall holds the result register and freezes the drain shift;
//    input is taken only while the result register is free or being emptied
//  synchronous active-low reset empties the chain and the result register
// ----------------------------------------------------------------------------
module sorted_draw_queue #(
  parameter int unsigned QUEUE_DEPTH = sdq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = sdq_pkg::KEY_BITS_DEF,
  localparam int unsigned DATA_W     = KEY_BITS + sdq_pkg::TEX_W + sdq_pkg::HANDLE_W,
  localparam int unsigned TDATA_W    = ((DATA_W + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input beats
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [TDATA_W-1:0]           in_tdata,   // sort_key, texture_id, item_handle
  input  logic                         in_tuser,   // cmd
  // result beats
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [TDATA_W-1:0]           out_tdata,  // out_key, out_texture, out_handle
  output logic [sdq_pkg::STATUS_W-1:0] out_tuser,  // status
  output logic                         out_tlast   // last_flag
);
  import sdq_pkg::*;

  localparam int unsigned TEX_LO = KEY_BITS;
  localparam int unsigned HDL_LO = KEY_BITS + TEX_W;

  // input fields
  logic [KEY_BITS-1:0] in_key;
  logic [TEX_W-1:0]    in_tex;
  logic [HANDLE_W-1:0] in_handle;

  assign in_key    = in_tdata[KEY_BITS-1:0];
  assign in_tex    = in_tdata[TEX_LO +: TEX_W];
  assign in_handle = in_tdata[HDL_LO +: HANDLE_W];

  // cell chain wiring
  logic                c_gt     [QUEUE_DEPTH];
  logic                c_valid  [QUEUE_DEPTH];
  logic [KEY_BITS-1:0] c_key    [QUEUE_DEPTH];
  logic [TEX_W-1:0]    c_tex    [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] c_handle [QUEUE_DEPTH];

  sdq_cell_ctrl_t ctrl;

  // control registers
  logic                draining_r, draining_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic [TEX_W-1:0]    out_tex_r, out_tex_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_last_r, out_last_nxt;
  sdq_status_t         out_status_r, out_status_nxt;

  logic out_free;
  logic in_accept;
  logic full;
  logic is_insert;
  logic is_drain;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !draining_r && out_free;
  assign in_accept = in_tvalid && in_tready;
  // occupancy is a thermometer from the head, so the tail cell flags full
  assign full      = c_valid[QUEUE_DEPTH-1];
  assign is_insert = in_accept && (in_tuser == CMD_INSERT);
  assign is_drain  = in_accept && (in_tuser == CMD_DRAIN);

  // insert only into a free slot; one head entry leaves per beat while the
  // result register can take it
  assign ctrl = '{ins: is_insert && !full, shift: draining_r && out_free};

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic                l_gt, l_valid, r_valid;
      logic [KEY_BITS-1:0] l_key, r_key;
      logic [TEX_W-1:0]    l_tex, r_tex;
      logic [HANDLE_W-1:0] l_handle, r_handle;

      if (gi == 0) begin : g_head
        // head has no left neighbor: on insert it never takes a shifted entry
        assign l_gt     = 1'b0;
        assign l_valid  = 1'b0;
        assign l_key    = '0;
        assign l_tex    = '0;
        assign l_handle = '0;
      end else begin : g_left
        assign l_gt     = c_gt[gi-1];
        assign l_valid  = c_valid[gi-1];
        assign l_key    = c_key[gi-1];
        assign l_tex    = c_tex[gi-1];
        assign l_handle = c_handle[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        // tail fills with an empty slot as the chain drains
        assign r_valid  = 1'b0;
        assign r_key    = '0;
        assign r_tex    = '0;
        assign r_handle = '0;
      end else begin : g_right
        assign r_valid  = c_valid[gi+1];
        assign r_key    = c_key[gi+1];
        assign r_tex    = c_tex[gi+1];
        assign r_handle = c_handle[gi+1];
      end

      sdq_cell #(
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .new_key      (in_key),
        .new_tex      (in_tex),
        .new_handle   (in_handle),
        .left_gt      (l_gt),
        .left_valid   (l_valid),
        .left_key     (l_key),
        .left_tex     (l_tex),
        .left_handle  (l_handle),
        .right_valid  (r_valid),
        .right_key    (r_key),
        .right_tex    (r_tex),
        .right_handle (r_handle),
        .gt           (c_gt[gi]),
        .valid        (c_valid[gi]),
        .key          (c_key[gi]),
        .tex          (c_tex[gi]),
        .handle       (c_handle[gi])
      );
    end
  endgenerate

  // result register and drain run control
  always_comb begin
    draining_nxt   = draining_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_key_nxt    = out_key_r;
    out_tex_nxt    = out_tex_r;
    out_handle_nxt = out_handle_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    if (ctrl.shift) begin
      // head entry goes out; it is the last when the next cell is empty
      out_valid_nxt  = 1'b1;
      out_key_nxt    = c_key[0];
      out_tex_nxt    = c_tex[0];
      out_handle_nxt = c_handle[0];
      out_last_nxt   = !c_valid[1];
      out_status_nxt = ST_ENTRY;
      draining_nxt   = c_valid[1];
    end else if (is_insert && full) begin
      // dropped insert echoes its own entry
      out_valid_nxt  = 1'b1;
      out_key_nxt    = in_key;
      out_tex_nxt    = in_tex;
      out_handle_nxt = in_handle;
      out_last_nxt   = 1'b1;
      out_status_nxt = ST_DROP;
    end else if (is_drain) begin
      if (c_valid[0]) begin
        draining_nxt = 1'b1;
      end else begin
        out_valid_nxt  = 1'b1;
        out_key_nxt    = '0;
        out_tex_nxt    = '0;
        out_handle_nxt = '0;
        out_last_nxt   = 1'b1;
        out_status_nxt = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      draining_r  <= draining_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_key_r    <= out_key_nxt;
    out_tex_r    <= out_tex_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W - DATA_W){1'b0}}, out_handle_r, out_tex_r, out_key_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // chain invariants: occupied cells are contiguous from the head and in order
  logic chain_packed;
  logic chain_sorted;

  always_comb begin
    chain_packed = 1'b1;
    chain_sorted = 1'b1;
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      if (c_valid[i+1] && !c_valid[i]) begin
        chain_packed = 1'b0;
      end
      if (c_valid[i+1] && ($signed(c_key[i]) > $signed(c_key[i+1]))) begin
        chain_sorted = 1'b0;
      end
    end
  end

`include "sorted_draw_queue_defines.svh"

  `SDQ_ASSERT_ALWAYS(a_chain_packed, chain_packed, "chain has a hole")
  `SDQ_ASSERT_ALWAYS(a_chain_sorted, chain_sorted, "chain keys out of order")
  `SDQ_ASSERT_SAME(a_drain_has_data, draining_r, c_valid[0], "drain run with empty head")
  `SDQ_ASSERT_NEXT(a_run_ends_empty, draining_r && ctrl.shift && out_last_nxt,
                   !c_valid[0] && !draining_r, "chain not empty after last drain beat")
  `SDQ_ASSERT_SAME(a_single_is_last, out_tvalid && (out_tuser != ST_ENTRY), out_tlast,
                   "status beat without last")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks sorted_draw_queue beat by beat: inserts are kept in signed key order
// in a shadow copy of the queue, and every drain, full-queue drop and empty
// drain result is compared field by field, under random idling on both sides
// ----------------------------------------------------------------------------
module tb;
  import sdq_pkg::*;

  localparam int unsigned DEPTH     = QUEUE_DEPTH_DEF;
  localparam int unsigned KEY_W     = KEY_BITS_DEF;
  localparam int unsigned DATA_W    = KEY_W + TEX_W + HANDLE_W;
  localparam int unsigned TDATA_W   = ((DATA_W + 7) / 8) * 8;
  localparam int unsigned ITEMS     = 430;
  localparam int unsigned TAIL      = 64;      // drain of a full chain plus margin
  localparam int unsigned MAX_CYCLE = 400000;  // far above the slowest legal run
  localparam int unsigned MAX_SHOWN = 100;     // mismatch lines printed at most

  // one held entry of the shadow queue
  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [TEX_W-1:0]        tex;
    logic [HANDLE_W-1:0]     hdl;
  } draw_entry_t;

  // one result beat as the block should give it
  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [TEX_W-1:0]        tex;
    logic [HANDLE_W-1:0]     hdl;
    logic                    last;
    sdq_status_t             status;
  } draw_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata;    // sort_key, texture_id, item_handle
  logic                 in_tuser;    // cmd
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;   // out_key, out_texture, out_handle
  logic [STATUS_W-1:0]  out_tuser;   // status
  logic                 out_tlast;   // last_flag

  // shadow of the chain contents and the results still owed
  draw_entry_t  held_entries[$];
  draw_result_t pending_results[$];

  int  err_count;
  int  items_sent;
  int  n_inserts;
  int  n_drains;
  int  n_empty;
  int  n_drops;
  int  n_beats;
  int  cycle_count;
  bit  idle_quiet;   // when set neither side idles
  bit  out_taken;    // a result beat went through at the last rising edge
  int  out_wait;

  sorted_draw_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("%0t timeout after %0d cycles, %0d results still owed", $time, cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // queue one owed result beat at the back
  function automatic void owe_result(draw_result_t r);
    pending_results = {pending_results, r};
  endfunction

  // expected beats for one accepted command, and the shadow queue update
  function automatic void order_draw_entries(logic cmd, logic signed [KEY_W-1:0] key,
                                             logic [TEX_W-1:0] tex,
                                             logic [HANDLE_W-1:0] hdl);
    draw_entry_t  e;
    draw_result_t r;
    int           pos;
    e.key = key;
    e.tex = tex;
    e.hdl = hdl;
    if (cmd == CMD_INSERT) begin
      n_inserts++;
      if (held_entries.size() >= DEPTH) begin
        // full: the entry is echoed back as dropped
        n_drops++;
        r = '{key: key, tex: tex, hdl: hdl, last: 1'b1, status: ST_DROP};
        owe_result(r);
      end else begin
        // after every entry with an equal key
        pos = held_entries.size();
        for (int i = 0; i < held_entries.size(); i++) begin
          if (held_entries[i].key > key) begin
            pos = i;
            break;
          end
        end
        held_entries.insert(pos, e);
      end
    end else begin
      n_drains++;
      if (held_entries.size() == 0) begin
        n_empty++;
        r = '{key: '0, tex: '0, hdl: '0, last: 1'b1, status: ST_EMPTY};
        owe_result(r);
      end else begin
        foreach (held_entries[i]) begin
          r.key    = held_entries[i].key;
          r.tex    = held_entries[i].tex;
          r.hdl    = held_entries[i].hdl;
          r.last   = (i == held_entries.size() - 1);
          r.status = ST_ENTRY;
          owe_result(r);
        end
        held_entries.delete();
      end
    end
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    draw_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      out_taken = 1'b1;
      n_beats++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("%0t unexpected result beat: key %0d tex %0d hdl %0d last %0b status %0d",
                   $time, $signed(out_tdata[KEY_W-1:0]), out_tdata[KEY_W +: TEX_W],
                   out_tdata[KEY_W+TEX_W +: HANDLE_W], out_tlast, out_tuser);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[KEY_W-1:0] !== exp_r.key) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("%0t key mismatch: expected %0d, got %0d", $time, exp_r.key,
                     $signed(out_tdata[KEY_W-1:0]));
        end
        if (out_tdata[KEY_W +: TEX_W] !== exp_r.tex) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("%0t texture mismatch: expected %0d, got %0d", $time, exp_r.tex,
                     out_tdata[KEY_W +: TEX_W]);
        end
        if (out_tdata[KEY_W+TEX_W +: HANDLE_W] !== exp_r.hdl) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("%0t handle mismatch: expected %0d, got %0d", $time, exp_r.hdl,
                     out_tdata[KEY_W+TEX_W +: HANDLE_W]);
        end
        if (out_tlast !== exp_r.last) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("%0t last mismatch: expected %0b, got %0b", $time, exp_r.last,
                     out_tlast);
        end
        if (out_tuser !== exp_r.status) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("%0t status mismatch: expected %0d, got %0d", $time, exp_r.status,
                     out_tuser);
        end
      end
    end
  end

  // receiver stall: a fresh wait is drawn after every result beat
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      out_wait  = idle_quiet ? 0 : $urandom_range(0, 19);
    end else if (out_wait > 0) begin
      out_wait--;
    end
    out_tready <= (out_wait == 0);
  end

  // one input beat: random gap, then hold until taken
  task automatic send_beat(input logic cmd, input logic signed [KEY_W-1:0] key,
                           input logic [TEX_W-1:0] tex, input logic [HANDLE_W-1:0] hdl);
    int gap;
    gap = idle_quiet ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(TDATA_W-DATA_W){1'b0}}, hdl, tex, key};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    order_draw_entries(cmd, key, tex, hdl);
  endtask

  task automatic send_insert(input logic signed [KEY_W-1:0] key, input logic [TEX_W-1:0] tex,
                             input logic [HANDLE_W-1:0] hdl);
    send_beat(CMD_INSERT, key, tex, hdl);
  endtask

  // drain beats carry random data that the block must ignore
  task automatic send_drain();
    send_beat(CMD_DRAIN, KEY_W'($urandom), TEX_W'($urandom), HANDLE_W'($urandom));
  endtask

  // mix of tie-prone small keys, full range and the extremes
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: pick_key = KEY_W'($signed($urandom_range(0, 8)) - 4);
      1, 2: pick_key = KEY_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: pick_key = {1'b1, {(KEY_W-1){1'b0}}};
          1: pick_key = {1'b0, {(KEY_W-1){1'b1}}};
          2: pick_key = '0;
          default: pick_key = '1;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_insert();
    send_insert(pick_key(), TEX_W'($urandom), HANDLE_W'($urandom));
  endtask

  // extremes of every field, empty drain, ties and a one-entry drain
  task automatic test_directed();
    send_drain();
    send_insert(16'sh7fff, 10'h3ff, 12'hfff);
    send_insert(16'sh8000, 10'h000, 12'h000);
    send_insert(16'sh0000, 10'h155, 12'haaa);
    send_insert(16'shffff, 10'h2aa, 12'h555);
    send_insert(16'sh0001, 10'h001, 12'h001);
    // equal keys must come out in arrival order, including at the tail
    send_insert(16'sh0007, 10'h010, 12'h100);
    send_insert(16'sh0007, 10'h020, 12'h200);
    send_insert(16'sh0007, 10'h030, 12'h300);
    send_insert(16'sh7fff, 10'h040, 12'h400);
    send_insert(16'sh8000, 10'h050, 12'h500);
    send_drain();
    send_drain();
    send_insert(16'sh1234, 10'h123, 12'h321);
    send_drain();
  endtask

  // fill to capacity, overfill, drain the full chain, then drain the empty one
  task automatic test_full_queue();
    for (int i = 0; i < DEPTH; i++) send_random_insert();
    send_random_insert();
    send_insert(16'sh8000, 10'h3ff, 12'hfff);
    send_drain();
    send_drain();
  endtask

  // mostly insert bursts closed by a drain, some overfills and lone drains
  task automatic test_random();
    int burst;
    while (items_sent < ITEMS) begin
      if ($urandom_range(0, 7) == 0) idle_quiet = ~idle_quiet;
      case ($urandom_range(0, 9))
        0: send_drain();
        1: begin
          burst = $urandom_range(DEPTH, DEPTH + 4);
          repeat (burst) send_random_insert();
          send_drain();
        end
        default: begin
          burst = $urandom_range(1, 10);
          repeat (burst) send_random_insert();
          send_drain();
        end
      endcase
    end
    idle_quiet = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_INSERT;
    idle_quiet = 1'b0;
    out_taken  = 1'b0;
    out_wait   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_queue();
    test_random();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("run: %0d beats sent, %0d inserts (%0d dropped full), %0d drains (%0d empty)",
             items_sent, n_inserts, n_drops, n_drains, n_empty);
    $display("run: %0d result beats checked, %0d mismatches", n_beats, err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
